// ----- sv/mtep_pkg.sv -----
package mtep_pkg;

  // Parse phase of the track byte stream
  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_TEMPO     = 4'd6,
    PH_SKIP      = 4'd7,
    PH_SYSEX_LEN = 4'd8,
    PH_HALT      = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_CONTROL  = 3'd2,
    KIND_PROGRAM  = 3'd3,
    KIND_PITCH    = 3'd4,
    KIND_TEMPO    = 3'd5,
    KIND_END      = 3'd6,
    KIND_ERROR    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LONG  = 3'd1,
    ERR_NO_RUN    = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_BAD_STAT  = 3'd4
  } err_e;

  // Status byte values
  localparam logic [7:0] STATUS_MIN  = 8'h80;
  localparam logic [7:0] SYSTEM_MIN  = 8'hF0;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ES = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;

  // High nibble of channel status bytes
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_CONTROL   = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES = 4'hD;
  localparam logic [3:0] HI_PITCH     = 4'hE;

  localparam logic [2:0]  VLQ_MAX_BYTES = 3'd4;
  localparam logic [1:0]  TEMPO_LAST    = 2'd2;
  localparam logic [27:0] TEMPO_LEN     = 28'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
    logic       song_start;
    logic       track_end;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  channel;
    logic [31:0] tick;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [23:0] value;
    logic [31:0] seq;
    err_e        err;
  } result_t;

endpackage

// ----- sv/mtep_in_stage.sv -----
module mtep_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  mtep_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              in_stall_o,
  output logic              item_valid_o,
  output mtep_pkg::in_item_t item_o
);

  logic               valid_q;
  mtep_pkg::in_item_t item_q;

  // Hold the byte while the parser cannot move it on
  assign in_stall_o   = valid_q && !advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ----- sv/mtep_parser.sv -----
module mtep_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mtep_pkg::in_item_t item_i,
  output logic               res_valid_o,
  output mtep_pkg::result_t  res_o
);

  mtep_pkg::phase_e ph_q, ph_d, ph0;
  logic [7:0]  run_q, run_d, run0;
  logic [7:0]  cur_q, cur_d, cur0;
  logic [31:0] tick_q, tick_d, tick0;
  logic [31:0] cnt_q, cnt_d, cnt0;
  logic [27:0] len_q, len_d, len0;
  logic [2:0]  lcnt_q, lcnt_d, lcnt0;
  logic [7:0]  held_q, held_d, held0;
  logic [7:0]  meta_q, meta_d, meta0;
  logic [27:0] skip_q, skip_d, skip0;
  logic [23:0] tempo_q, tempo_d, tempo0;
  logic [1:0]  tcnt_q, tcnt_d, tcnt0;

  logic        clr;
  logic [7:0]  b;
  logic [27:0] vlen;
  logic [2:0]  vcnt;
  logic        vdone;
  logic        vlong;
  logic        have;
  logic        take_d1;
  logic [7:0]  d1_status;
  logic [27:0] skip_n;
  mtep_pkg::kind_e kind;
  mtep_pkg::err_e  err;
  logic [7:0]  ea, eb;
  logic [23:0] ev;

  // Apply track and song start before the byte is parsed
  always_comb begin
    clr    = item_i.track_start || item_i.song_start;
    ph0    = clr ? mtep_pkg::PH_DELTA : ph_q;
    run0   = clr ? 8'd0  : run_q;
    cur0   = clr ? 8'd0  : cur_q;
    tick0  = clr ? 32'd0 : tick_q;
    len0   = clr ? 28'd0 : len_q;
    lcnt0  = clr ? 3'd0  : lcnt_q;
    held0  = clr ? 8'd0  : held_q;
    meta0  = clr ? 8'd0  : meta_q;
    skip0  = clr ? 28'd0 : skip_q;
    tempo0 = clr ? 24'd0 : tempo_q;
    tcnt0  = clr ? 2'd0  : tcnt_q;
    cnt0   = item_i.song_start ? 32'd0 : cnt_q;
  end

  // Variable-length quantity step
  always_comb begin
    b     = item_i.data_byte;
    vlen  = {len0[20:0], b[6:0]};
    vcnt  = lcnt0 + 3'd1;
    vdone = !b[7];
    vlong = b[7] && (vcnt >= mtep_pkg::VLQ_MAX_BYTES);
    skip_n = (skip0 != 28'd0) ? skip0 - 28'd1 : skip0;
  end

  // Next parser state and result
  always_comb begin
    ph_d      = ph0;
    run_d     = run0;
    cur_d     = cur0;
    tick_d    = tick0;
    cnt_d     = cnt0;
    len_d     = len0;
    lcnt_d    = lcnt0;
    held_d    = held0;
    meta_d    = meta0;
    skip_d    = skip0;
    tempo_d   = tempo0;
    tcnt_d    = tcnt0;
    have      = 1'b0;
    take_d1   = 1'b0;
    d1_status = cur0;
    kind      = mtep_pkg::KIND_NOTE_OFF;
    err       = mtep_pkg::ERR_NONE;
    ea        = 8'd0;
    eb        = 8'd0;
    ev        = 24'd0;

    case (ph0)
      mtep_pkg::PH_DELTA: begin
        len_d  = vlen;
        lcnt_d = vcnt;
        if (vdone) begin
          tick_d = tick0 + {4'd0, vlen};
          len_d  = 28'd0;
          lcnt_d = 3'd0;
          ph_d   = mtep_pkg::PH_STATUS;
        end else if (vlong) begin
          err = mtep_pkg::ERR_TOO_LONG;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (b < mtep_pkg::STATUS_MIN) begin
          if (run0 == 8'd0) begin
            err = mtep_pkg::ERR_NO_RUN;
          end else begin
            // running status: this byte is the first data byte
            cnt_d     = cnt0 + 32'd1;
            cur_d     = run0;
            take_d1   = 1'b1;
            d1_status = run0;
          end
        end else begin
          cnt_d = cnt0 + 32'd1;
          cur_d = b;
          if (b < mtep_pkg::SYSTEM_MIN) begin
            run_d = b;
            ph_d  = mtep_pkg::PH_DATA1;
          end else if (b == mtep_pkg::ST_META) begin
            run_d = 8'd0;
            ph_d  = mtep_pkg::PH_META_TYPE;
          end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ES) begin
            run_d  = 8'd0;
            len_d  = 28'd0;
            lcnt_d = 3'd0;
            ph_d   = mtep_pkg::PH_SYSEX_LEN;
          end else begin
            err = mtep_pkg::ERR_BAD_STAT;
          end
        end
      end
      mtep_pkg::PH_DATA1: begin
        take_d1   = 1'b1;
        d1_status = cur0;
      end
      mtep_pkg::PH_DATA2: begin
        case (cur0[7:4])
          mtep_pkg::HI_NOTE_OFF, mtep_pkg::HI_NOTE_ON: begin
            have = 1'b1;
            kind = (cur0[7:4] == mtep_pkg::HI_NOTE_ON && b != 8'd0) ?
                   mtep_pkg::KIND_NOTE_ON : mtep_pkg::KIND_NOTE_OFF;
            ea   = held0;
            eb   = b;
          end
          mtep_pkg::HI_CONTROL: begin
            have = 1'b1;
            kind = mtep_pkg::KIND_CONTROL;
            ea   = held0;
            eb   = b;
          end
          mtep_pkg::HI_PITCH: begin
            have = 1'b1;
            kind = mtep_pkg::KIND_PITCH;
            ev   = {9'd0, b, 7'd0} | {16'd0, held0};
          end
          default: begin
          end
        endcase
        ph_d = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_META_TYPE: begin
        meta_d = b;
        len_d  = 28'd0;
        lcnt_d = 3'd0;
        ph_d   = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
        len_d  = vlen;
        lcnt_d = vcnt;
        if (vdone) begin
          if (ph0 == mtep_pkg::PH_META_LEN && meta0 == mtep_pkg::META_TEMPO &&
              vlen == mtep_pkg::TEMPO_LEN) begin
            tempo_d = 24'd0;
            tcnt_d  = 2'd0;
            ph_d    = mtep_pkg::PH_TEMPO;
          end else begin
            if (ph0 == mtep_pkg::PH_META_LEN && meta0 == mtep_pkg::META_EOT) begin
              have = 1'b1;
              kind = mtep_pkg::KIND_END;
            end
            skip_d = vlen;
            ph_d   = (vlen != 28'd0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
          end
          len_d  = 28'd0;
          lcnt_d = 3'd0;
        end else if (vlong) begin
          err = mtep_pkg::ERR_TOO_LONG;
        end
      end
      mtep_pkg::PH_TEMPO: begin
        tempo_d = {tempo0[15:0], b};
        tcnt_d  = tcnt0 + 2'd1;
        if (tcnt0 == mtep_pkg::TEMPO_LAST) begin
          have   = 1'b1;
          kind   = mtep_pkg::KIND_TEMPO;
          ev     = {tempo0[15:0], b};
          tcnt_d = 2'd0;
          ph_d   = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_SKIP: begin
        skip_d = skip_n;
        if (skip_n == 28'd0) begin
          ph_d = mtep_pkg::PH_DELTA;
        end
      end
      default: begin
      end
    endcase

    // First data byte, direct or under running status
    if (take_d1) begin
      case (d1_status[7:4])
        mtep_pkg::HI_PROGRAM: begin
          have = 1'b1;
          kind = mtep_pkg::KIND_PROGRAM;
          ea   = b;
          ph_d = mtep_pkg::PH_DELTA;
        end
        mtep_pkg::HI_CHAN_PRES: begin
          ph_d = mtep_pkg::PH_DELTA;
        end
        default: begin
          held_d = b;
          ph_d   = mtep_pkg::PH_DATA2;
        end
      endcase
    end

    // A track that ends mid-message is truncated
    if (ph0 != mtep_pkg::PH_HALT && err == mtep_pkg::ERR_NONE &&
        item_i.track_end && ph_d != mtep_pkg::PH_DELTA) begin
      err = mtep_pkg::ERR_TRUNCATED;
    end
    if (err != mtep_pkg::ERR_NONE) begin
      ph_d = mtep_pkg::PH_HALT;
    end
  end

  // Shape the result
  always_comb begin
    res_valid_o = (err != mtep_pkg::ERR_NONE) || have;
    res_o.tick  = tick_d;
    res_o.err   = err;
    if (err != mtep_pkg::ERR_NONE) begin
      res_o.kind        = mtep_pkg::KIND_ERROR;
      res_o.channel     = 4'd0;
      res_o.first_data  = 8'd0;
      res_o.second_data = 8'd0;
      res_o.value       = 24'd0;
      res_o.seq         = cnt_d;
    end else begin
      res_o.kind        = kind;
      res_o.channel     = cur_d[3:0];
      res_o.first_data  = ea;
      res_o.second_data = eb;
      res_o.value       = ev;
      res_o.seq         = cnt_d - 32'd1;
    end
  end

  // Advance parser state on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= mtep_pkg::PH_DELTA;
      run_q   <= 8'd0;
      cur_q   <= 8'd0;
      tick_q  <= 32'd0;
      cnt_q   <= 32'd0;
      len_q   <= 28'd0;
      lcnt_q  <= 3'd0;
      held_q  <= 8'd0;
      meta_q  <= 8'd0;
      skip_q  <= 28'd0;
      tempo_q <= 24'd0;
      tcnt_q  <= 2'd0;
    end else if (step_i) begin
      ph_q    <= ph_d;
      run_q   <= run_d;
      cur_q   <= cur_d;
      tick_q  <= tick_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      lcnt_q  <= lcnt_d;
      held_q  <= held_d;
      meta_q  <= meta_d;
      skip_q  <= skip_d;
      tempo_q <= tempo_d;
      tcnt_q  <= tcnt_d;
    end
  end

endmodule

// ----- sv/mtep_out_reg.sv -----
module mtep_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              res_valid_i,
  input  mtep_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output mtep_pkg::result_t res_o
);

  logic              valid_q;
  mtep_pkg::result_t res_q;

  // Slot is free when empty or when the held transaction leaves now
  assign advance_o   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= step_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- sv/midi_track_event_parser_core.sv -----
// A byte accepted into the input register is parsed there, and its result is captured
// in the result register that drives the outputs; an output stall holds both registers.
// Throughput: one track byte per cycle while the output is not stalled; every
// byte is parsed in a single pass between the input register and the result register.
// Reset: asynchronous, clears the parser state, sequence counter and both stage valids.
module midi_track_event_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        track_start_i,
  input  logic        song_start_i,
  input  logic        track_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [3:0]  midi_channel_o,
  output logic [31:0] event_tick_o,
  output logic [7:0]  first_data_o,
  output logic [7:0]  second_data_o,
  output logic [23:0] event_value_o,
  output logic [31:0] sequence_number_o,
  output logic [2:0]  error_code_o
);

  mtep_pkg::in_item_t in_item;
  mtep_pkg::in_item_t item;
  mtep_pkg::result_t  res;
  mtep_pkg::result_t  out_res;
  logic               item_valid;
  logic               advance;
  logic               step;
  logic               res_valid;

  assign in_item.data_byte   = data_byte_i;
  assign in_item.track_start = track_start_i;
  assign in_item.song_start  = song_start_i;
  assign in_item.track_end   = track_end_i;

  // Parse the registered byte whenever the result slot can take it
  assign step = item_valid && advance;

  mtep_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .in_stall_o   (in_stall_o),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mtep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign event_kind_o      = out_res.kind;
  assign midi_channel_o    = out_res.channel;
  assign event_tick_o      = out_res.tick;
  assign first_data_o      = out_res.first_data;
  assign second_data_o     = out_res.second_data;
  assign event_value_o     = out_res.value;
  assign sequence_number_o = out_res.seq;
  assign error_code_o      = out_res.err;

endmodule

// ----- bench/tb_midi_track_event_parser_core.sv -----
module tb_midi_track_event_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         ITEMS_PER_MODE = 630;
  localparam logic [3:0] HI_POLY_AT     = 4'hA;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        track_start = 1'b0;
  logic        song_start = 1'b0;
  logic        track_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_kind;
  logic [3:0]  midi_channel;
  logic [31:0] event_tick;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [23:0] event_value;
  logic [31:0] sequence_number;
  logic [2:0]  error_code;

  // Bytes waiting to be sent, the byte on the bus, and events still to arrive
  mtep_pkg::in_item_t byte_fifo[$];
  mtep_pkg::in_item_t track_buf[$];
  mtep_pkg::in_item_t drv_item;
  mtep_pkg::result_t  event_fifo[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_requested = 0;
  int holds_done = 0;
  int hold_left = 0;
  int errors = 0;
  int quiet = 0;
  int n_items = 0;
  logic [7:0] gen_run;

  // Parser shadow state
  mtep_pkg::phase_e ps_phase;
  logic [7:0]  ps_running;
  logic [7:0]  ps_status;
  logic [7:0]  ps_held;
  logic [7:0]  ps_meta;
  logic [31:0] ps_tick;
  logic [31:0] ps_count;
  logic [27:0] ps_len;
  logic [2:0]  ps_len_n;
  logic [27:0] ps_skip;
  logic [23:0] ps_tempo;
  logic [1:0]  ps_tempo_n;

  midi_track_event_parser_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .track_start_i    (track_start),
    .song_start_i     (song_start),
    .track_end_i      (track_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .event_kind_o     (event_kind),
    .midi_channel_o   (midi_channel),
    .event_tick_o     (event_tick),
    .first_data_o     (first_data),
    .second_data_o    (second_data),
    .event_value_o    (event_value),
    .sequence_number_o(sequence_number),
    .error_code_o     (error_code)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Track parser prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_track();
    ps_phase   = mtep_pkg::PH_DELTA;
    ps_running = '0;
    ps_status  = '0;
    ps_tick    = '0;
    ps_len     = '0;
    ps_len_n   = '0;
    ps_held    = '0;
    ps_meta    = '0;
    ps_skip    = '0;
    ps_tempo   = '0;
    ps_tempo_n = '0;
  endfunction

  // Shift one byte into a variable-length quantity: 1 done, 0 more, -1 too long
  function automatic int vlq_feed(input logic [7:0] b);
    ps_len   = {ps_len[20:0], b[6:0]};
    ps_len_n = ps_len_n + 3'd1;
    if (!b[7]) return 1;
    if (ps_len_n >= mtep_pkg::VLQ_MAX_BYTES) return -1;
    return 0;
  endfunction

  function automatic bit parse_byte(input mtep_pkg::in_item_t it,
                                    output mtep_pkg::result_t res);
    logic [7:0]  b;
    logic [3:0]  hi;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ev;
    mtep_pkg::kind_e kind;
    mtep_pkg::err_e  err;
    bit          have;
    bit          data1;
    int          r;
    b     = it.data_byte;
    ea    = '0;
    eb    = '0;
    ev    = '0;
    kind  = mtep_pkg::KIND_NOTE_OFF;
    err   = mtep_pkg::ERR_NONE;
    have  = 1'b0;
    data1 = 1'b0;
    res   = '0;
    if (it.song_start) ps_count = '0;
    if (it.song_start || it.track_start) clear_track();
    if (ps_phase == mtep_pkg::PH_HALT) return 1'b0;

    case (ps_phase)
      mtep_pkg::PH_DELTA: begin
        r = vlq_feed(b);
        if (r > 0) begin
          ps_tick  = ps_tick + {4'd0, ps_len};
          ps_len   = '0;
          ps_len_n = '0;
          ps_phase = mtep_pkg::PH_STATUS;
        end else if (r < 0) begin
          err = mtep_pkg::ERR_TOO_LONG;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (b < mtep_pkg::STATUS_MIN) begin
          // data byte under running status doubles as first data
          if (ps_running == 8'h00) begin
            err = mtep_pkg::ERR_NO_RUN;
          end else begin
            ps_count  = ps_count + 32'd1;
            ps_status = ps_running;
            ps_phase  = mtep_pkg::PH_DATA1;
            data1     = 1'b1;
          end
        end else begin
          ps_count  = ps_count + 32'd1;
          ps_status = b;
          if (b < mtep_pkg::SYSTEM_MIN) begin
            ps_running = b;
            ps_phase   = mtep_pkg::PH_DATA1;
          end else if (b == mtep_pkg::ST_META) begin
            ps_running = '0;
            ps_phase   = mtep_pkg::PH_META_TYPE;
          end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ES) begin
            ps_running = '0;
            ps_len     = '0;
            ps_len_n   = '0;
            ps_phase   = mtep_pkg::PH_SYSEX_LEN;
          end else begin
            err = mtep_pkg::ERR_BAD_STAT;
          end
        end
      end
      mtep_pkg::PH_DATA1: data1 = 1'b1;
      mtep_pkg::PH_DATA2: begin
        hi = ps_status[7:4];
        if (hi == mtep_pkg::HI_NOTE_OFF || hi == mtep_pkg::HI_NOTE_ON) begin
          have = 1'b1;
          kind = (hi == mtep_pkg::HI_NOTE_ON && b != 8'h00) ?
                 mtep_pkg::KIND_NOTE_ON : mtep_pkg::KIND_NOTE_OFF;
          ea   = ps_held;
          eb   = b;
        end else if (hi == mtep_pkg::HI_CONTROL) begin
          have = 1'b1;
          kind = mtep_pkg::KIND_CONTROL;
          ea   = ps_held;
          eb   = b;
        end else if (hi == mtep_pkg::HI_PITCH) begin
          have = 1'b1;
          kind = mtep_pkg::KIND_PITCH;
          ev   = 24'(ps_held) | (24'(b) << 7);
        end
        ps_phase = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_META_TYPE: begin
        ps_meta  = b;
        ps_len   = '0;
        ps_len_n = '0;
        ps_phase = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
        r = vlq_feed(b);
        if (r < 0) begin
          err = mtep_pkg::ERR_TOO_LONG;
        end else if (r > 0) begin
          if (ps_phase == mtep_pkg::PH_META_LEN && ps_meta == mtep_pkg::META_TEMPO &&
              ps_len == mtep_pkg::TEMPO_LEN) begin
            ps_tempo   = '0;
            ps_tempo_n = '0;
            ps_phase   = mtep_pkg::PH_TEMPO;
          end else begin
            if (ps_phase == mtep_pkg::PH_META_LEN && ps_meta == mtep_pkg::META_EOT) begin
              have = 1'b1;
              kind = mtep_pkg::KIND_END;
            end
            ps_skip  = ps_len;
            ps_phase = (ps_skip != '0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
          end
          ps_len   = '0;
          ps_len_n = '0;
        end
      end
      mtep_pkg::PH_TEMPO: begin
        ps_tempo   = {ps_tempo[15:0], b};
        ps_tempo_n = ps_tempo_n + 2'd1;
        if (ps_tempo_n == 2'd3) begin
          have       = 1'b1;
          kind       = mtep_pkg::KIND_TEMPO;
          ev         = ps_tempo;
          ps_tempo_n = '0;
          ps_phase   = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_SKIP: begin
        if (ps_skip != '0) ps_skip = ps_skip - 28'd1;
        if (ps_skip == '0) ps_phase = mtep_pkg::PH_DELTA;
      end
      default: ;
    endcase

    // Finish a channel message at its first data position
    if (data1) begin
      hi = ps_status[7:4];
      if (hi == mtep_pkg::HI_PROGRAM) begin
        have     = 1'b1;
        kind     = mtep_pkg::KIND_PROGRAM;
        ea       = b;
        ps_phase = mtep_pkg::PH_DELTA;
      end else if (hi == mtep_pkg::HI_CHAN_PRES) begin
        ps_phase = mtep_pkg::PH_DELTA;
      end else begin
        ps_held  = b;
        ps_phase = mtep_pkg::PH_DATA2;
      end
    end

    if (err == mtep_pkg::ERR_NONE && it.track_end && ps_phase != mtep_pkg::PH_DELTA) begin
      err = mtep_pkg::ERR_TRUNCATED;
    end
    res.tick = ps_tick;
    if (err != mtep_pkg::ERR_NONE) begin
      ps_phase = mtep_pkg::PH_HALT;
      res.kind = mtep_pkg::KIND_ERROR;
      res.seq  = ps_count;
      res.err  = err;
      return 1'b1;
    end
    if (have) begin
      res.kind        = kind;
      res.channel     = ps_status[3:0];
      res.first_data  = ea;
      res.second_data = eb;
      res.value       = ev;
      res.seq         = ps_count - 32'd1;
      res.err         = mtep_pkg::ERR_NONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, monitor and watchdog
  // ---------------------------------------------------------------------------

  // Predict each accepted byte, then hold or advance the input bus
  always @(posedge clk_i) begin : drive_bytes
    mtep_pkg::result_t res;
    bit                got;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        got = parse_byte(drv_item, res);
        if (got) event_fifo.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (byte_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item    = byte_fifo.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= drv_item.data_byte;
          track_start <= drv_item.track_start;
          song_start  <= drv_item.song_start;
          track_end   <= drv_item.track_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check each event transaction, then pick the stall for the next cycle
  always @(posedge clk_i) begin : watch_events
    mtep_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (event_fifo.size() == 0) begin
          $display("%0t ns: unexpected event: expected none, actual kind %0d seq 0x%0h",
                   $time, event_kind, sequence_number);
          errors++;
        end else begin
          want = event_fifo.pop_front();
          cmp_field("event_kind", 32'(want.kind), 32'(event_kind));
          cmp_field("midi_channel", 32'(want.channel), 32'(midi_channel));
          cmp_field("event_tick", want.tick, event_tick);
          cmp_field("first_data", 32'(want.first_data), 32'(first_data));
          cmp_field("second_data", 32'(want.second_data), 32'(second_data));
          cmp_field("event_value", 32'(want.value), 32'(event_value));
          cmp_field("sequence_number", want.seq, sequence_number);
          cmp_field("error_code", 32'(want.err), 32'(error_code));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_done != holds_requested) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else if (rst_ni) begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb_midi_track_event_parser_core: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_data();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [27:0] rand_len();
    if ($urandom_range(0, 9) == 0) return 28'($urandom_range(128, 160));
    return 28'($urandom_range(0, 5));
  endfunction

  task automatic add(input logic [7:0] b);
    mtep_pkg::in_item_t it;
    it = '0;
    it.data_byte = b;
    track_buf.push_back(it);
  endtask

  // Flag the track boundaries and move the track to the send queue
  task automatic commit_track(input bit song, input bit tail_end);
    track_buf[0].track_start = 1'b1;
    track_buf[0].song_start  = song;
    if (tail_end) track_buf[track_buf.size() - 1].track_end = 1'b1;
    foreach (track_buf[i]) byte_fifo.push_back(track_buf[i]);
    n_items += track_buf.size();
    track_buf.delete();
  endtask

  // Emit a variable-length quantity, sometimes padded with leading zero groups
  task automatic add_vlq(input logic [27:0] v);
    int n;
    int pad;
    int k;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    pad = (n < 4 && $urandom_range(0, 7) == 0) ? int'($urandom_range(1, 4 - n)) : 0;
    repeat (pad) add(8'h80);
    for (k = n - 1; k >= 0; k--) add({(k != 0), 7'(v >> (7 * k))});
  endtask

  task automatic add_delta(input bit big);
    int sel;
    sel = $urandom_range(0, 9);
    if (big) add_vlq(28'h0FFFFFFF);
    else if (sel < 7) add_vlq(28'($urandom_range(0, 127)));
    else if (sel < 9) add_vlq(28'($urandom_range(0, 16383)));
    else add_vlq(28'($urandom));
  endtask

  task automatic add_meta(input logic [7:0] mtype, input logic [27:0] len);
    add(mtep_pkg::ST_META);
    add(mtype);
    add_vlq(len);
    repeat (len) add(8'($urandom));
    gen_run = '0;
  endtask

  // Channel message, reusing the running status now and then
  task automatic add_channel(input logic [3:0] hi);
    logic [7:0] st;
    int         nd;
    if (gen_run != 8'h00 && $urandom_range(0, 2) == 0) begin
      st = gen_run;
      add(8'($urandom_range(0, 127)));
      nd = (st[7:4] == mtep_pkg::HI_PROGRAM || st[7:4] == mtep_pkg::HI_CHAN_PRES) ? 0 : 1;
    end else begin
      st = {hi, 4'($urandom_range(0, 15))};
      add(st);
      gen_run = st;
      nd = (hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_CHAN_PRES) ? 1 : 2;
    end
    repeat (nd) add(rand_data());
  endtask

  // Random bytes with random track flags
  task automatic add_noise();
    mtep_pkg::in_item_t it;
    repeat ($urandom_range(1, 8)) begin
      it.data_byte   = 8'($urandom);
      it.track_start = ($urandom_range(0, 7) == 0);
      it.song_start  = ($urandom_range(0, 15) == 0);
      it.track_end   = ($urandom_range(0, 7) == 0);
      byte_fifo.push_back(it);
      n_items++;
    end
  endtask

  // One track: mostly well formed, some broken on purpose
  task automatic gen_track(input bit song);
    int          n;
    int          i;
    int          broke;
    int          sel;
    int          cut;
    bit          big;
    logic [7:0]  st;
    logic [27:0] len;
    gen_run = '0;
    big   = ($urandom_range(0, 9) == 0);
    n     = big ? $urandom_range(18, 24) : $urandom_range(1, 10);
    broke = $urandom_range(0, 15);
    // data byte before any status in the track
    if (broke == 3) begin
      add_delta(1'b0);
      add(8'($urandom_range(0, 127)));
    end
    for (i = 0; i < n; i++) begin
      if (i == n / 2 && broke == 1) begin
        repeat (4) add(8'($urandom_range(128, 255)));
        continue;
      end
      add_delta(big);
      if (i == n / 2 && broke == 2) begin
        st = 8'($urandom_range(8'hF1, 8'hFE));
        if (st == mtep_pkg::ST_SYSEX_ES) st = 8'hF1;
        add(st);
      end else if (i == n / 2 && broke == 4) begin
        add(mtep_pkg::ST_META);
        add(8'($urandom_range(0, 127)));
        repeat (4) add(8'($urandom_range(128, 255)));
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 4) add_channel(mtep_pkg::HI_NOTE_ON);
        else if (sel < 6) add_channel(mtep_pkg::HI_NOTE_OFF);
        else if (sel == 6) add_channel(HI_POLY_AT);
        else if (sel < 9) add_channel(mtep_pkg::HI_CONTROL);
        else if (sel < 11) add_channel(mtep_pkg::HI_PROGRAM);
        else if (sel == 11) add_channel(mtep_pkg::HI_CHAN_PRES);
        else if (sel < 14) add_channel(mtep_pkg::HI_PITCH);
        else if (sel < 16) begin
          add_meta(mtep_pkg::META_TEMPO, ($urandom_range(0, 5) == 0) ? rand_len() : 28'd3);
        end
        else if (sel == 16) add_meta(8'($urandom_range(0, 127)), rand_len());
        else if (sel == 17) begin
          add(($urandom_range(0, 1) != 0) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_SYSEX_ES);
          len = rand_len();
          add_vlq(len);
          repeat (len) add(8'($urandom));
          gen_run = '0;
        end else begin
          add_channel((gen_run != 8'h00) ? gen_run[7:4] : mtep_pkg::HI_NOTE_ON);
        end
      end
    end
    add_delta(1'b0);
    if ($urandom_range(0, 7) == 0) add_meta(mtep_pkg::META_EOT, 28'($urandom_range(1, 3)));
    else add_meta(mtep_pkg::META_EOT, 28'd0);
    // end the track early on a random byte
    if (broke == 0) begin
      cut = $urandom_range(0, track_buf.size() - 2);
      track_buf[cut].track_end = 1'b1;
      commit_track(song, 1'b0);
    end else begin
      commit_track(song, 1'b1);
    end
  endtask

  // Hold off the sender until every event has come back
  task automatic wait_drain();
    do @(negedge clk_i); while (byte_fifo.size() != 0 || in_valid || event_fifo.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int mode;
    int target;
    clear_track();
    ps_count = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    send_idle_pct <= 11;
    recv_idle_pct <= 48;
    // note on, running status with zero velocity, longest delta with program,
    // tempo, end of track
    add(8'h00); add(8'h90); add(8'h3C); add(8'h64);
    add(8'h7F); add(8'h3C); add(8'h00);
    add(8'hFF); add(8'hFF); add(8'hFF); add(8'h7F); add(8'hC5); add(8'h10);
    add(8'h00); add(mtep_pkg::ST_META); add(mtep_pkg::META_TEMPO); add(8'h03);
    add(8'h07); add(8'hA1); add(8'h20);
    add(8'h00); add(mtep_pkg::ST_META); add(mtep_pkg::META_EOT); add(8'h00);
    commit_track(1'b1, 1'b1);
    // over-long delta
    add(8'hFF); add(8'hFF); add(8'hFF); add(8'hFF);
    commit_track(1'b0, 1'b0);
    // data byte with no running status
    add(8'h00); add(8'h40);
    commit_track(1'b0, 1'b0);
    // undefined system status
    add(8'h00); add(8'hF4);
    commit_track(1'b0, 1'b1);
    // track cut inside a control change
    add(8'h00); add(8'hB1); add(8'h07);
    commit_track(1'b0, 1'b1);
    wait_drain();

    for (mode = 0; mode < 3; mode++) begin
      @(negedge clk_i);
      send_idle_pct <= (mode == 0) ? 11 : (mode == 1) ? 48 : 0;
      recv_idle_pct <= (mode == 0) ? 48 : (mode == 1) ? 11 : 0;
      target = n_items + ITEMS_PER_MODE;
      while (n_items < target) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        gen_track($urandom_range(0, 7) == 0);
      end
      // back up the pipeline while bytes keep coming
      if (mode == 2) holds_requested <= holds_requested + 1;
      wait_drain();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0 && event_fifo.size() == 0) begin
      $display("tb_midi_track_event_parser_core: PASS");
    end else begin
      $display("tb_midi_track_event_parser_core: FAIL");
    end
    $finish;
  end

endmodule
